// ===== hw/rtl/per_group_round_robin_scheduler_core_defines.svh =====
// ----------------------------------------------------------------------------
// Scheduler core assertion macros
// Shared assertion shorthands for the round robin scheduler checks. Each macro
// samples on the rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PER_GROUP_ROUND_ROBIN_SCHEDULER_CORE_DEFINES_SVH
`define PER_GROUP_ROUND_ROBIN_SCHEDULER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGRR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define PGRR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed: next-cycle implication");

`endif

// ===== hw/rtl/pgrr_pkg.sv =====
// ----------------------------------------------------------------------------
// Scheduler core package
// Field widths, request and status codes, and the result item type shared by
// the scheduler core, its checker and the testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package pgrr_pkg;

  // Field widths of the input and result items.
  localparam int REQ_W  = 2;
  localparam int GID_W  = 4;
  localparam int TASK_W = 22;
  localparam int ST_W   = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_CREATE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SWITCH = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

  // One result item.
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic              wake_valid;
    logic [TASK_W-1:0] wake_task;
    logic              caller_sleeps;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/per_group_round_robin_scheduler_core.sv =====
// From accept to out_valid, create passes S_CR_G and, for a nonempty ring, S_CR_L;
// delete passes S_DL_G and the walk in S_DL_W, then S_DL_S when a successor is woken;
// switch alternates S_SW_G and S_SW_T, then S_SW_W when a new task is woken; each ends
// in S_RES. One item is worked on at a time and the next is taken once the result is in
// the output register; the delete walk visits one ring node per cycle and the switch
// search checks the groups in order. After reset every group record is cleared, with in_ready low.
// ----------------------------------------------------------------------------
// Per-group round robin scheduler core
// Keeps one circular task ring per group in shared slot memories, with a free
// slot stack, and serves create, delete and switch requests.
// ----------------------------------------------------------------------------
`default_nettype none

module per_group_round_robin_scheduler_core
  import pgrr_pkg::*;
#(
  parameter int GROUPS = 16,
  parameter int SLOTS  = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [REQ_W-1:0]  in_req_type,
  input  wire logic [GID_W-1:0]  in_group_id,
  input  wire logic [TASK_W-1:0] in_task_id,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [ST_W-1:0]   out_status,
  output logic                   out_wake_valid,
  output logic      [TASK_W-1:0] out_wake_task,
  output logic                   out_caller_sleeps
);

  localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int GXW = (GW > GID_W) ? GW : GID_W;

  // One group record: active flag and head, tail and current slot.
  typedef struct packed {
    logic          act;
    logic [SW-1:0] head;
    logic [SW-1:0] tail;
    logic [SW-1:0] cur;
  } grp_t;

  localparam int GRP_W = $bits(grp_t);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CR_G,
    S_CR_L,
    S_DL_G,
    S_DL_W,
    S_DL_S,
    S_SW_G,
    S_SW_T,
    S_SW_W,
    S_RES
  } state_t;

  state_t            state_r, state_nxt;
  logic [GW-1:0]     clr_r, clr_nxt;
  logic [GW-1:0]     scan_r, scan_nxt;
  logic [GW-1:0]     gid_r, gid_nxt;
  logic [TASK_W-1:0] task_r, task_nxt;
  grp_t              grp_r, grp_nxt;
  logic [SW-1:0]     node_r, node_nxt;
  logic [SW-1:0]     prev_r, prev_nxt;
  logic [SW:0]       free_cnt_r, free_cnt_nxt;
  logic [SW:0]       fresh_r, fresh_nxt;
  res_t              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;

  // Memory ports.
  logic              grp_we;
  logic [GW-1:0]     grp_waddr, grp_raddr;
  grp_t              grp_wdata, grp_rdata;
  logic [GRP_W-1:0]  grp_rbits;
  logic              task_we;
  logic [SW-1:0]     task_waddr, task_raddr;
  logic [TASK_W-1:0] task_wdata, task_rdata;
  logic              next_we;
  logic [SW-1:0]     next_waddr, next_raddr, next_wdata, next_rdata;
  logic              free_we;
  logic [SW-1:0]     free_waddr, free_raddr, free_wdata, free_rdata;

  logic [GXW-1:0]    gid_ext;
  logic [GW-1:0]     gidx;
  logic              gid_bad;
  logic              last_grp;
  logic              have_free;
  logic              have_fresh;
  logic [SW-1:0]     alloc_idx;

  assign gid_ext    = GXW'(in_group_id);
  assign gidx       = gid_ext[GW-1:0];
  assign gid_bad    = 32'(in_group_id) >= 32'(GROUPS);
  assign last_grp   = scan_r == GW'(GROUPS - 1);
  assign have_free  = free_cnt_r != '0;
  assign have_fresh = fresh_r != (SW + 1)'(SLOTS);
  assign alloc_idx  = have_free ? free_rdata : fresh_r[SW-1:0];
  assign grp_rdata  = grp_t'(grp_rbits);

  // Group records: {active, head, tail, current}.
  pgrr_ram #(.WIDTH(GRP_W), .DEPTH(GROUPS)) u_grp_ram (
    .clk   (clk),
    .we    (grp_we),
    .waddr (grp_waddr),
    .wdata (grp_wdata),
    .raddr (grp_raddr),
    .rdata (grp_rbits)
  );

  // Task id held in each slot.
  pgrr_ram #(.WIDTH(TASK_W), .DEPTH(SLOTS)) u_task_ram (
    .clk   (clk),
    .we    (task_we),
    .waddr (task_waddr),
    .wdata (task_wdata),
    .raddr (task_raddr),
    .rdata (task_rdata)
  );

  // Ring successor of each slot.
  pgrr_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_rdata)
  );

  // Stack of released slots; fresh_r is the next slot never handed out yet.
  pgrr_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

  assign in_ready = state_r == S_IDLE;

  // Request sequencer.
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    scan_nxt     = scan_r;
    gid_nxt      = gid_r;
    task_nxt     = task_r;
    grp_nxt      = grp_r;
    node_nxt     = node_r;
    prev_nxt     = prev_r;
    free_cnt_nxt = free_cnt_r;
    fresh_nxt    = fresh_r;
    res_nxt      = res_r;
    out_res_nxt  = out_res_r;
    out_valid_nxt = out_valid_r && !out_ready;

    grp_we     = 1'b0;
    grp_waddr  = gid_r;
    grp_wdata  = grp_r;
    grp_raddr  = gid_r;
    task_we    = 1'b0;
    task_waddr = node_r;
    task_wdata = task_r;
    task_raddr = node_r;
    next_we    = 1'b0;
    next_waddr = node_r;
    next_wdata = prev_r;
    next_raddr = node_r;
    free_we    = 1'b0;
    free_waddr = free_cnt_r[SW-1:0];
    free_wdata = node_r;
    free_raddr = free_cnt_r[SW-1:0] - 1'b1;

    case (state_r)
      // Mark every group inactive after reset.
      S_CLEAR: begin
        grp_we    = 1'b1;
        grp_waddr = clr_r;
        grp_wdata = '0;
        if (clr_r == GW'(GROUPS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      // Take an item and start its first memory reads.
      S_IDLE: begin
        if (in_valid) begin
          task_nxt = in_task_id;
          gid_nxt  = gidx;
          res_nxt  = '0;
          grp_raddr = gidx;
          case (in_req_type)
            REQ_CREATE: begin
              if (gid_bad) begin
                res_nxt.status = ST_NOTFOUND;
                state_nxt = S_RES;
              end else begin
                state_nxt = S_CR_G;
              end
            end
            REQ_DELETE: begin
              if (gid_bad) begin
                res_nxt.status = ST_NOTFOUND;
                state_nxt = S_RES;
              end else begin
                state_nxt = S_DL_G;
              end
            end
            REQ_SWITCH: begin
              scan_nxt  = '0;
              grp_raddr = '0;
              state_nxt = S_SW_G;
            end
            default: begin
              res_nxt.status = ST_NOTFOUND;
              state_nxt = S_RES;
            end
          endcase
        end
      end

      // Create: allocate a slot and link it into the ring.
      S_CR_G: begin
        if (!have_free && !have_fresh) begin
          res_nxt.status = ST_FULL;
          state_nxt = S_RES;
        end else begin
          if (have_free) begin
            free_cnt_nxt = free_cnt_r - 1'b1;
          end else begin
            fresh_nxt = fresh_r + 1'b1;
          end
          task_we    = 1'b1;
          task_waddr = alloc_idx;
          next_we    = 1'b1;
          next_waddr = alloc_idx;
          grp_we     = 1'b1;
          if (!grp_rdata.act) begin
            grp_wdata  = '{act: 1'b1, head: alloc_idx, tail: alloc_idx, cur: alloc_idx};
            next_wdata = alloc_idx;
            res_nxt.status = ST_OK;
            state_nxt = S_RES;
          end else begin
            grp_wdata      = grp_rdata;
            grp_wdata.tail = alloc_idx;
            next_wdata     = grp_rdata.head;
            node_nxt       = alloc_idx;
            prev_nxt       = grp_rdata.tail;
            state_nxt      = S_CR_L;
          end
        end
      end

      // Create: point the old tail at the new slot.
      S_CR_L: begin
        next_we    = 1'b1;
        next_waddr = prev_r;
        next_wdata = node_r;
        res_nxt.status        = ST_OK;
        res_nxt.caller_sleeps = 1'b1;
        state_nxt = S_RES;
      end

      // Delete: check the group and start the walk at the head.
      S_DL_G: begin
        if (!grp_rdata.act) begin
          res_nxt.status = ST_EMPTY;
          state_nxt = S_RES;
        end else begin
          grp_nxt    = grp_rdata;
          prev_nxt   = grp_rdata.tail;
          node_nxt   = grp_rdata.head;
          task_raddr = grp_rdata.head;
          next_raddr = grp_rdata.head;
          state_nxt  = S_DL_W;
        end
      end

      // Delete: one ring node per cycle until a match or the tail.
      S_DL_W: begin
        if (task_rdata == task_r) begin
          free_we      = 1'b1;
          free_cnt_nxt = free_cnt_r + 1'b1;
          grp_we       = 1'b1;
          if (next_rdata == node_r) begin
            grp_wdata.act  = 1'b0;
            res_nxt.status = ST_OK;
            state_nxt = S_RES;
          end else begin
            next_we    = 1'b1;
            next_waddr = prev_r;
            next_wdata = next_rdata;
            if (node_r == grp_r.head) begin
              grp_wdata.head = next_rdata;
            end
            if (node_r == grp_r.tail) begin
              grp_wdata.tail = prev_r;
            end
            grp_wdata.cur = next_rdata;
            task_raddr = next_rdata;
            state_nxt  = S_DL_S;
          end
        end else if (node_r == grp_r.tail) begin
          res_nxt.status = ST_NOTFOUND;
          state_nxt = S_RES;
        end else begin
          prev_nxt   = node_r;
          node_nxt   = next_rdata;
          task_raddr = next_rdata;
          next_raddr = next_rdata;
        end
      end

      // Delete: wake the successor.
      S_DL_S: begin
        res_nxt.status     = ST_OK;
        res_nxt.wake_valid = 1'b1;
        res_nxt.wake_task  = task_rdata;
        state_nxt = S_RES;
      end

      // Switch: look at one group record.
      S_SW_G: begin
        grp_nxt = grp_rdata;
        if (grp_rdata.act) begin
          task_raddr = grp_rdata.cur;
          next_raddr = grp_rdata.cur;
          state_nxt  = S_SW_T;
        end else if (last_grp) begin
          res_nxt.status = ST_NOTFOUND;
          state_nxt = S_RES;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          grp_raddr = scan_r + 1'b1;
        end
      end

      // Switch: compare the current task of an active group.
      S_SW_T: begin
        if (task_rdata == task_r) begin
          if (next_rdata == grp_r.cur) begin
            res_nxt.status = ST_OK;
            state_nxt = S_RES;
          end else begin
            grp_we        = 1'b1;
            grp_waddr     = scan_r;
            grp_wdata.cur = next_rdata;
            task_raddr    = next_rdata;
            state_nxt     = S_SW_W;
          end
        end else if (last_grp) begin
          res_nxt.status = ST_NOTFOUND;
          state_nxt = S_RES;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          grp_raddr = scan_r + 1'b1;
          state_nxt = S_SW_G;
        end
      end

      // Switch: wake the new current task, the caller sleeps.
      S_SW_W: begin
        res_nxt.status        = ST_OK;
        res_nxt.wake_valid    = 1'b1;
        res_nxt.wake_task     = task_rdata;
        res_nxt.caller_sleeps = 1'b1;
        state_nxt = S_RES;
      end

      // Move the result item into the output register once it is free.
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, counters and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_cnt_r  <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_cnt_r  <= free_cnt_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r    <= scan_nxt;
    gid_r     <= gid_nxt;
    task_r    <= task_nxt;
    grp_r     <= grp_nxt;
    node_r    <= node_nxt;
    prev_r    <= prev_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_wake_valid    = out_res_r.wake_valid;
  assign out_wake_task     = out_res_r.wake_task;
  assign out_caller_sleeps = out_res_r.caller_sleeps;

endmodule

`default_nettype wire

// ===== hw/rtl/pgrr_ram.sv =====
// ----------------------------------------------------------------------------
// Scheduler generic RAM
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pgrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pgrr_checker.sv =====
// ----------------------------------------------------------------------------
// Scheduler core checker
// Port-level checks on the result items of the scheduler core, bound to every
// instance of the scheduler core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_group_round_robin_scheduler_core_defines.svh"

module pgrr_checker
  import pgrr_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ST_W-1:0]   out_status,
  input wire logic              out_wake_valid,
  input wire logic [TASK_W-1:0] out_wake_task,
  input wire logic              out_caller_sleeps
);

  // A task id is only reported when a wake is requested.
  `PGRR_ASSERT_IMP(a_wake_task_zero, out_valid && !out_wake_valid, out_wake_task == '0)

  // A wake only comes with a successful request.
  `PGRR_ASSERT_IMP(a_wake_ok, out_valid && out_wake_valid, out_status == ST_OK)

  // The caller is only put to sleep by a successful request.
  `PGRR_ASSERT_IMP(a_sleep_ok, out_valid && out_caller_sleeps, out_status == ST_OK)

  // A stalled result item stays valid and keeps its status and wake task.
  `PGRR_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_status) && $stable(out_wake_task))

  // Only one item is worked on at a time.
  `PGRR_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)

endmodule

bind per_group_round_robin_scheduler_core pgrr_checker u_pgrr_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Round robin scheduler core testbench
// Drives create, delete and switch requests into the scheduler core with random
// idle gaps on both channels, predicts each result from a shadow copy of the
// per-group task rings, and compares every result item field by field.
// ----------------------------------------------------------------------------

module testbench;
  import pgrr_pkg::*;

  localparam int GROUPS         = 16;
  localparam int SLOTS          = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int PHASE_ITEMS    = 100;

  // The request code that the block does not define.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // Operation mixes of the random phases.
  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_t;

  // Shadow of the task rings and the queue of predicted result items.
  class ring_sched_predictor;
    logic [TASK_W-1:0] ring_task [GROUPS][SLOTS];
    int ring_len [GROUPS];
    int cur_pos [GROUPS];
    int used_slots;
    res_t pending_results [$];
    int mismatches;

    function new();
      foreach (ring_len[g]) begin
        ring_len[g] = 0;
        cur_pos[g] = 0;
      end
      used_slots = 0;
      mismatches = 0;
    endfunction

    function res_t make_result(logic [ST_W-1:0] st, logic wv, logic [TASK_W-1:0] wt,
                               logic sl);
      res_t r;
      r.status = st;
      r.wake_valid = wv;
      r.wake_task = wv ? wt : '0;
      r.caller_sleeps = sl;
      return r;
    endfunction

    // Work out the result of one accepted request and update the rings.
    function void note_request(logic [REQ_W-1:0] req, logic [GID_W-1:0] gid,
                               logic [TASK_W-1:0] tid);
      res_t r;
      int g;
      int pos;
      int succ;
      bit found;
      g = int'(gid);
      found = 1'b0;
      pos = 0;
      case (req)
        REQ_CREATE: begin
          if (used_slots == SLOTS) begin
            r = make_result(ST_FULL, 1'b0, '0, 1'b0);
          end else begin
            ring_task[g][ring_len[g]] = tid;
            used_slots++;
            if (ring_len[g] == 0) begin
              cur_pos[g] = 0;
              r = make_result(ST_OK, 1'b0, '0, 1'b0);
            end else begin
              r = make_result(ST_OK, 1'b0, '0, 1'b1);
            end
            ring_len[g]++;
          end
        end
        REQ_DELETE: begin
          if (ring_len[g] == 0) begin
            r = make_result(ST_EMPTY, 1'b0, '0, 1'b0);
          end else begin
            // The first match from the head is removed.
            for (int i = 0; i < ring_len[g]; i++) begin
              if (!found && ring_task[g][i] == tid) begin
                found = 1'b1;
                pos = i;
              end
            end
            if (!found) begin
              r = make_result(ST_NOTFOUND, 1'b0, '0, 1'b0);
            end else if (ring_len[g] == 1) begin
              ring_len[g] = 0;
              used_slots--;
              r = make_result(ST_OK, 1'b0, '0, 1'b0);
            end else begin
              // The successor wraps to the head when the tail is removed.
              succ = (pos == ring_len[g] - 1) ? 0 : pos;
              for (int i = pos; i < ring_len[g] - 1; i++)
                ring_task[g][i] = ring_task[g][i + 1];
              ring_len[g]--;
              used_slots--;
              cur_pos[g] = succ;
              r = make_result(ST_OK, 1'b1, ring_task[g][succ], 1'b0);
            end
          end
        end
        REQ_SWITCH: begin
          // The lowest-numbered group whose current task is the caller.
          for (int i = 0; i < GROUPS; i++) begin
            if (!found && ring_len[i] > 0 && ring_task[i][cur_pos[i]] == tid) begin
              found = 1'b1;
              g = i;
            end
          end
          if (!found) begin
            r = make_result(ST_NOTFOUND, 1'b0, '0, 1'b0);
          end else if (ring_len[g] == 1) begin
            r = make_result(ST_OK, 1'b0, '0, 1'b0);
          end else begin
            cur_pos[g] = (cur_pos[g] + 1) % ring_len[g];
            r = make_result(ST_OK, 1'b1, ring_task[g][cur_pos[g]], 1'b1);
          end
        end
        default: begin
          r = make_result(ST_NOTFOUND, 1'b0, '0, 1'b0);
        end
      endcase
      pending_results.push_back(r);
    endfunction

    // Compare one accepted result item with the oldest prediction.
    function void check_result(logic [ST_W-1:0] st, logic wv, logic [TASK_W-1:0] wt,
                               logic sl);
      res_t exp_res;
      if (pending_results.size() == 0) begin
        $error("result item with no request outstanding: status %0d", st);
        mismatches++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (st !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, st);
        mismatches++;
      end
      if (wv !== exp_res.wake_valid) begin
        $error("wake_valid: expected %0d, got %0d", exp_res.wake_valid, wv);
        mismatches++;
      end
      if (wt !== exp_res.wake_task) begin
        $error("wake_task: expected 0x%0h, got 0x%0h", exp_res.wake_task, wt);
        mismatches++;
      end
      if (sl !== exp_res.caller_sleeps) begin
        $error("caller_sleeps: expected %0d, got %0d", exp_res.caller_sleeps, sl);
        mismatches++;
      end
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    // A random nonempty group, or -1 when every ring is empty.
    function int random_active_group();
      int start;
      start = $urandom_range(GROUPS - 1);
      for (int i = 0; i < GROUPS; i++)
        if (ring_len[(start + i) % GROUPS] > 0) return (start + i) % GROUPS;
      return -1;
    endfunction

    function logic [TASK_W-1:0] any_task(int g);
      return ring_task[g][$urandom_range(ring_len[g] - 1)];
    endfunction

    function logic [TASK_W-1:0] current_task(int g);
      return ring_task[g][cur_pos[g]];
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [REQ_W-1:0] in_req_type;
  logic [GID_W-1:0] in_group_id;
  logic [TASK_W-1:0] in_task_id;
  logic out_valid;
  logic out_ready;
  logic [ST_W-1:0] out_status;
  logic out_wake_valid;
  logic [TASK_W-1:0] out_wake_task;
  logic out_caller_sleeps;

  ring_sched_predictor sched = new();
  bit calm = 1'b0;
  int quiet_cycles = 0;

  per_group_round_robin_scheduler_core #(
    .GROUPS(GROUPS),
    .SLOTS (SLOTS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_group_id      (in_group_id),
    .in_task_id       (in_task_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_wake_valid   (out_wake_valid),
    .out_wake_task    (out_wake_task),
    .out_caller_sleeps(out_caller_sleeps)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample both channels, predict and check, and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sched.note_request(in_req_type, in_group_id, in_task_id);
      if (out_valid && out_ready)
        sched.check_result(out_status, out_wake_valid, out_wake_task, out_caller_sleeps);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side back-pressure: random stall bursts, none in the last part.
  initial begin
    int span;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (calm || $urandom_range(2) != 0) begin
        out_ready <= 1'b1;
        span = $urandom_range(30, 1);
      end else begin
        out_ready <= 1'b0;
        span = $urandom_range(19, 1);
      end
      repeat (span) @(negedge clk);
    end
  end

  // Present one item at a falling edge and hold it until it is accepted.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [GID_W-1:0] gid,
                           input logic [TASK_W-1:0] tid);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_group_id <= gid;
    in_task_id <= tid;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (!calm && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(negedge clk);
    end
  endtask

  // Hold the sender off until every predicted result has arrived.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (sched.pending_count() != 0) @(negedge clk);
  endtask

  // One random request; most are well formed against the current rings.
  task automatic send_random_item(input op_mix_t mix);
    int roll;
    int create_pct;
    int delete_pct;
    int switch_pct;
    int g;
    logic [REQ_W-1:0] req;
    logic [GID_W-1:0] gid;
    logic [TASK_W-1:0] tid;
    case (mix)
      MIX_FILL: begin
        create_pct = 80; delete_pct = 10; switch_pct = 9;
      end
      MIX_BALANCED: begin
        create_pct = 35; delete_pct = 35; switch_pct = 25;
      end
      default: begin
        create_pct = 10; delete_pct = 68; switch_pct = 20;
      end
    endcase
    roll = $urandom_range(99);
    gid = ($urandom_range(1) == 0) ? GID_W'($urandom_range(3)) : GID_W'($urandom);
    tid = TASK_W'($urandom);
    if (roll < create_pct) begin
      req = REQ_CREATE;
      roll = $urandom_range(99);
      if (roll < 35) begin
        tid = TASK_W'($urandom_range(7));
      end else if (roll < 55) begin
        // Reuse a live task id so duplicates span rings and groups.
        g = sched.random_active_group();
        if (g >= 0) tid = sched.any_task(g);
      end
    end else if (roll < create_pct + delete_pct) begin
      req = REQ_DELETE;
      g = sched.random_active_group();
      if (g >= 0 && $urandom_range(99) < 80) begin
        gid = GID_W'(g);
        tid = sched.any_task(g);
      end else if ($urandom_range(1) == 0) begin
        tid = TASK_W'($urandom_range(7));
      end
    end else if (roll < create_pct + delete_pct + switch_pct) begin
      req = REQ_SWITCH;
      g = sched.random_active_group();
      if (g >= 0 && $urandom_range(99) < 75)
        tid = sched.current_task(g);
      else if ($urandom_range(1) == 0)
        tid = TASK_W'($urandom_range(7));
    end else begin
      req = REQ_UNKNOWN;
    end
    send_item(req, gid, tid);
  endtask

  initial begin
    op_mix_t mix;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_CREATE;
    in_group_id = '0;
    in_task_id = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: empty rings, single-task rings, duplicates, tail removal.
    send_item(REQ_DELETE, 4'd0, 22'd0);
    send_item(REQ_SWITCH, 4'd7, 22'd12);
    send_item(REQ_UNKNOWN, 4'd0, 22'd0);
    send_item(REQ_CREATE, 4'd0, 22'd0);
    send_item(REQ_SWITCH, 4'd0, 22'd0);
    send_item(REQ_CREATE, 4'd0, 22'h3FFFFF);
    send_item(REQ_CREATE, 4'd0, 22'd5);
    send_item(REQ_CREATE, 4'd15, 22'h3FFFFF);
    send_item(REQ_SWITCH, 4'd15, 22'd0);
    send_item(REQ_SWITCH, 4'd0, 22'h3FFFFF);
    send_item(REQ_DELETE, 4'd0, 22'd99);
    send_item(REQ_DELETE, 4'd0, 22'd5);
    send_item(REQ_CREATE, 4'd0, 22'd0);
    send_item(REQ_DELETE, 4'd0, 22'd0);
    send_item(REQ_DELETE, 4'd15, 22'h3FFFFF);
    send_item(REQ_DELETE, 4'd15, 22'h3FFFFF);
    send_item(REQ_UNKNOWN, 4'd15, 22'h3FFFFF);
    send_item(REQ_SWITCH, 4'd0, 22'h2AAAAA);
    send_item(REQ_DELETE, 4'd0, 22'd0);
    send_item(REQ_DELETE, 4'd0, 22'h3FFFFF);
    wait_until_drained();
    @(negedge clk);

    // Random part: fill, balanced and drain phases, twice over.
    for (int phase = 0; phase < 6; phase++) begin
      mix = op_mix_t'(phase % 3);
      if (phase == 5) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_item(mix);
      if (phase == 2) begin
        wait_until_drained();
        @(negedge clk);
      end
    end

    // Let the last results come out, then a quiet tail in which any extra result item is flagged.
    in_valid <= 1'b0;
    while (sched.pending_count() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sched.mismatches == 0 && sched.pending_count() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pgrr_pkg.sv
hw/rtl/pgrr_ram.sv
hw/rtl/per_group_round_robin_scheduler_core.sv
hw/rtl/pgrr_checker.sv
tb/testbench.sv
